// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Clocked on clk, disabled while rst is high; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property: expression must hold at every sampled edge.
`define TUHT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Next-cycle property: antecedent implies consequent.
`define TUHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tuht_pkg.sv =====
// Package for the triangle union hit test: sizes, coordinate types, codes
// and the control/flag structs between the sequencer and the edge unit.
`timescale 1ns / 1ps

package tuht_pkg;

  localparam int MAX_TRIANGLES = 64;
  localparam int COORD_BITS    = 16;

  localparam int CORNERS = 3 * MAX_TRIANGLES;
  localparam int ADDR_W  = (CORNERS > 1) ? $clog2(CORNERS) : 1;
  localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } corner_t;

  // item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_QUERY = 2'd2;

  typedef struct packed {
    logic clear;   // drop sign flags before a new triangle
    logic mul_en;  // issue one product this cycle
    logic half;    // 0: (ux-px)*(wy-py), 1: (wx-px)*(uy-py)
  } edge_ctrl_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } edge_flags_t;

endpackage

// ===== rtl/core/triangle_union_hit_test.sv =====
// Top level of the triangle union hit test: sequencer, corner store and
// shared edge unit. Depends on tuht_pkg, tuht_corner_ram, tuht_edge_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Direction | Transfer condition   | Payload
// ----------+-----------+----------------------+---------------------------------
// item      | in        | start && !busy       | kind, ax, ay, bx, by, cx, cy, px, py
// result    | out       | done (one cycle)     | inside_res, status
//
// Sequence: an add writes its three corners into the store, then gives
// its result; an add to a full store, or a query on an empty store,
// gives its result in the next cycle. For each triangle visited, a
// query reads the three corners over the single RAM read port, then
// forms the six product terms and folds their signs through the one
// shared multiplier and checks the flags; it stops at the first hit.
// Reset: synchronous rst empties the store (count to zero); corner data
// is not cleared. busy stays high from transfer until the result cycle
// ends. The receiver cannot stall: done is a one-cycle strobe.

module triangle_union_hit_test (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             kind,
  input  tuht_pkg::coord_t ax,
  input  tuht_pkg::coord_t ay,
  input  tuht_pkg::coord_t bx,
  input  tuht_pkg::coord_t by,
  input  tuht_pkg::coord_t cx,
  input  tuht_pkg::coord_t cy,
  input  tuht_pkg::coord_t px,
  input  tuht_pkg::coord_t py,
  output logic             done,
  output logic             inside_res,
  output logic [1:0]       status
);
  import tuht_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]        state;
  logic [2:0]        step;      // corner index / read phase / product step
  logic [CNT_W-1:0]  count;     // stored triangles
  logic [CNT_W-1:0]  tri_idx;   // triangle under test
  logic [ADDR_W-1:0] rd_base;   // first corner of tri_idx
  logic [ADDR_W-1:0] wr_base;

  corner_t c0, c1, c2;          // add latch, then triangle under test
  coord_t  pt_x, pt_y;
  logic    res_inside;
  logic [1:0] res_status;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  corner_t           ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  corner_t           ram_rdata;

  edge_ctrl_t  ectrl;
  edge_flags_t eflags;
  corner_t     eu, ew;
  logic [1:0]  edge_u;
  logic [1:0]  edge_w;

  function automatic corner_t pick(corner_t a, corner_t b, corner_t c, logic [1:0] i);
    corner_t r;
    unique case (i)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_RESP);
  assign inside_res = res_inside;
  assign status     = res_status;

  // 3 * count, built as shift and add
  assign wr_base = ADDR_W'(({2'b00, count} << 1) + {2'b00, count});

  always_comb begin
    ram_we    = (state == S_ADD);
    ram_waddr = ADDR_W'(wr_base + ADDR_W'(step[1:0]));
    ram_wdata = pick(c0, c1, c2, step[1:0]);
    ram_re    = (state == S_LOAD) && (step < 3'd3);
    ram_raddr = ADDR_W'(rd_base + ADDR_W'(step[1:0]));
  end

  // edge e uses corners e and (e+1) mod 3; two products per edge
  always_comb begin
    edge_u = step[2:1];
    unique case (edge_u)
      2'd0:    edge_w = 2'd1;
      2'd1:    edge_w = 2'd2;
      default: edge_w = 2'd0;
    endcase
    eu = pick(c0, c1, c2, edge_u);
    ew = pick(c0, c1, c2, edge_w);
    ectrl.clear  = (state == S_LOAD) && (step == 3'd3);
    ectrl.mul_en = (state == S_MUL) && (step < 3'd6);
    ectrl.half   = step[0];
  end

  tuht_corner_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tuht_edge_unit u_edge (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ectrl),
    .u     (eu),
    .w     (ew),
    .px    (pt_x),
    .py    (pt_y),
    .flags (eflags)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            c0   <= '{y: ay, x: ax};
            c1   <= '{y: by, x: bx};
            c2   <= '{y: cy, x: cx};
            pt_x <= px;
            pt_y <= py;
            res_inside <= 1'b0;
            step <= '0;
            if (kind == KIND_ADD) begin
              if (count >= CNT_W'(MAX_TRIANGLES)) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                state <= S_ADD;
              end
            end else begin
              res_status <= ST_QUERY;
              tri_idx    <= '0;
              rd_base    <= '0;
              if (count == '0) begin
                state <= S_RESP;
              end else begin
                state <= S_LOAD;
              end
            end
          end
        end
        S_ADD: begin
          step <= step + 3'd1;
          if (step == 3'd2) begin
            count      <= CNT_W'(count + 1'b1);
            res_status <= ST_ADDED;
            state      <= S_RESP;
          end
        end
        S_LOAD: begin
          // registered read data arrives in the cycle after its address
          unique case (step[1:0])
            2'd1:    c0 <= ram_rdata;
            2'd2:    c1 <= ram_rdata;
            2'd3:    c2 <= ram_rdata;
            default: ;
          endcase
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_MUL;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_MUL: begin
          // last step drains the final compare
          if (step == 3'd6) begin
            state <= S_CHECK;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CHECK: begin
          step <= '0;
          if (!(eflags.pos && eflags.neg)) begin
            res_inside <= 1'b1;
            state      <= S_RESP;
          end else if (CNT_W'(tri_idx + 1'b1) == count) begin
            state <= S_RESP;
          end else begin
            tri_idx <= CNT_W'(tri_idx + 1'b1);
            rd_base <= ADDR_W'(rd_base + ADDR_W'(3));
            state   <= S_LOAD;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `TUHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `TUHT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held past one cycle")
  `TUHT_ASSERT(a_count_max, count <= CNT_W'(MAX_TRIANGLES), "triangle count over capacity")
  `TUHT_ASSERT(a_add_outside, !(done && (status != ST_QUERY) && inside_res), "add result has inside set")

endmodule

// ===== rtl/core/tuht_corner_ram.sv =====
// Corner store: one write port, one read port with registered data.
// Depends on tuht_pkg for depth and corner type.
`timescale 1ns / 1ps

module tuht_corner_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [tuht_pkg::ADDR_W-1:0] waddr,
  input  tuht_pkg::corner_t        wdata,
  input  logic                     re,
  input  logic [tuht_pkg::ADDR_W-1:0] raddr,
  output tuht_pkg::corner_t        rdata
);
  import tuht_pkg::*;

  corner_t mem [CORNERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tuht_edge_unit.sv =====
// Shared multiply/compare unit: one cross product term per mul_en cycle,
// then the sign of a-b folded into pos/neg flags. Depends on tuht_pkg.
`timescale 1ns / 1ps

module tuht_edge_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  tuht_pkg::edge_ctrl_t ctrl,
  input  tuht_pkg::corner_t    u,
  input  tuht_pkg::corner_t    w,
  input  tuht_pkg::coord_t     px,
  input  tuht_pkg::coord_t     py,
  output tuht_pkg::edge_flags_t flags
);
  import tuht_pkg::*;

  diff_t d1;
  diff_t d2;
  prod_t prod;
  prod_t prod_a;
  logic  prod_vld;
  logic  prod_half;

  always_comb begin
    if (ctrl.half) begin
      d1 = diff_t'(w.x) - diff_t'(px);
      d2 = diff_t'(u.y) - diff_t'(py);
    end else begin
      d1 = diff_t'(u.x) - diff_t'(px);
      d2 = diff_t'(w.y) - diff_t'(py);
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul_en;
    end
    if (ctrl.mul_en) begin
      prod      <= prod_t'(d1) * prod_t'(d2);
      prod_half <= ctrl.half;
    end
  end

  // hold first term, compare when the second one lands
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ctrl.clear) begin
      flags <= '0;
    end else if (prod_vld && prod_half) begin
      if (prod_a > prod) begin
        flags.pos <= 1'b1;
      end
      if (prod_a < prod) begin
        flags.neg <= 1'b1;
      end
    end
    if (prod_vld && !prod_half) begin
      prod_a <= prod;
    end
  end

endmodule
